FILE: hdl/b2b_pkg.sv
// Shared types, constants and mixing functions for the BLAKE2b hash engine.
package b2b_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_GA,
        ST_GB,
        ST_FOLD,
        ST_POST,
        ST_OUT
    } state_t;

    typedef enum logic {
        REG_DIGEST_LENGTH = 1'b0,
        REG_KEY_LENGTH    = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } quad_t;

    localparam logic [63:0] IV_TAB [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] PARAM_CONST = 64'h0000_0000_0101_0000;

    localparam logic [3:0] PERM_TAB [10][16] = '{
        '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
        '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
        '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
        '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
        '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
        '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
        '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
        '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
        '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
        '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}
    };

    // working vector indices of each of the eight mixes in a round
    localparam logic [3:0] GA_TAB [8] = '{0, 1, 2, 3, 0, 1, 2, 3};
    localparam logic [3:0] GB_TAB [8] = '{4, 5, 6, 7, 5, 6, 7, 4};
    localparam logic [3:0] GC_TAB [8] = '{8, 9, 10, 11, 10, 11, 8, 9};
    localparam logic [3:0] GD_TAB [8] = '{12, 13, 14, 15, 15, 12, 13, 14};

    function automatic quad_t mix_first(input quad_t q, input logic [63:0] m);
        quad_t r;
        logic [63:0] t;
        r.a = q.a + q.b + m;
        t   = q.d ^ r.a;
        r.d = {t[31:0], t[63:32]};
        r.c = q.c + r.d;
        t   = q.b ^ r.c;
        r.b = {t[23:0], t[63:24]};
        return r;
    endfunction

    function automatic quad_t mix_second(input quad_t q, input logic [63:0] m);
        quad_t r;
        logic [63:0] t;
        r.a = q.a + q.b + m;
        t   = q.d ^ r.a;
        r.d = {t[15:0], t[63:16]};
        r.c = q.c + r.d;
        t   = q.b ^ r.c;
        r.b = {t[62:0], t[63]};
        return r;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < n)
            begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

FILE: hdl/b2b_if.sv
// Handshake channel interfaces for message, digest and register writes.
interface b2b_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_word;
    logic [3:0]  bytes_valid;
    logic        last_word;
    modport source (output valid, msg_word, bytes_valid, last_word, input ready);
    modport sink   (input valid, msg_word, bytes_valid, last_word, output ready);
endinterface

interface b2b_dig_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [3:0]  digest_bytes;
    logic        digest_last;
    modport source (output valid, digest_word, digest_bytes, digest_last, input ready);
    modport sink   (input valid, digest_word, digest_bytes, digest_last, output ready);
endinterface

interface b2b_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/blake2b_hash_engine_core.sv
// Top level of the BLAKE2b hash engine: buffering, round sequencer and digest output.
//
// Usage: message words enter on msg, eight little-endian bytes each; only the
// word marked last_word may carry fewer than eight (bytes_valid). For a keyed
// hash the key, zero-padded to 128 bytes, goes first as sixteen words. After
// the last word the digest leaves on dig as ceil(digest_length/8) words, the
// final one flagged digest_last. Registers are written on cfg (index 0:
// digest_length, index 1: key_length); the user must write them only while
// the engine is idle, as the block does not enforce it; cfg is always
// ready. A word that needs no compression goes straight into the block
// buffer. A word arriving on a full block is taken, then the input stalls
// for a compression; the round sequencer runs one half mix per cycle from
// the block buffer. The last word adds one more compression before the
// first digest word shows. A stalled receiver holds the digest word
// steady; no new message word is taken until the whole digest has gone.
// Reset restores the default registers and leaves the engine idle with no
// message open.
module blake2b_hash_engine_core #(
    parameter int ROUND_COUNT = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    b2b_msg_if.sink       msg,
    b2b_dig_if.source     dig,
    b2b_cfg_if.sink       cfg
);

    localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

    b2b_pkg::state_t state_reg, state_next;

    logic [6:0]   dl_reg, kl_reg;
    logic [63:0]  chain_reg [8];
    logic [63:0]  chain_next [8];
    logic [63:0]  v_reg [16];
    logic [63:0]  v_next [16];
    logic [63:0]  cnt_lo_reg, cnt_lo_next, cnt_hi_reg, cnt_hi_next;
    logic [7:0]   fill_reg, fill_next;
    logic         open_reg, open_next;
    logic         final_reg, final_next;
    logic [4:0]   lim_reg, lim_next;
    logic [RW-1:0] round_reg, round_next;
    logic [3:0]   row_reg, row_next;
    logic [2:0]   g_reg, g_next;
    logic [2:0]   oidx_reg, oidx_next;
    logic [63:0]  pend_word_reg, pend_word_next;
    logic [3:0]   pend_nb_reg, pend_nb_next;
    logic         pend_last_reg, pend_last_next;

    logic [63:0]  mem [16];
    logic [63:0]  rd_data_reg;
    logic         rd_zero_reg;
    logic [3:0]   rd_addr;
    logic         wr_en;
    logic [3:0]   wr_addr;
    logic [63:0]  wr_data;

    logic [6:0]   dl_clamp, kl_clamp;
    logic [3:0]   nb_eff;
    logic [63:0]  word_eff;
    logic [7:0]   fill_base, fill_sum;
    logic [63:0]  mword;
    logic [3:0]   words;
    logic [6:0]   rem_bytes;
    logic [3:0]   out_cnt;
    b2b_pkg::quad_t q_in, q_out;
    logic [63:0]  lo_add;
    logic [63:0]  lo_sum;

    assign dl_clamp = (dl_reg == 7'd0) ? 7'd1 : ((dl_reg > 7'd64) ? 7'd64 : dl_reg);
    assign kl_clamp = (kl_reg > 7'd64) ? 7'd64 : kl_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dl_reg <= 7'd64;
            kl_reg <= 7'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                b2b_pkg::REG_DIGEST_LENGTH: dl_reg <= cfg.data;
                b2b_pkg::REG_KEY_LENGTH:    kl_reg <= cfg.data;
                default:                    dl_reg <= dl_reg;
            endcase
        end
    end

    // block buffer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_zero_reg <= ({1'b0, rd_addr} >= lim_reg);
    end

    always_comb
    begin
        case (state_reg)
            b2b_pkg::ST_GA: rd_addr = b2b_pkg::PERM_TAB[row_reg][{g_reg, 1'b1}];
            b2b_pkg::ST_GB:
            begin
                if (g_reg != 3'd7)
                    rd_addr = b2b_pkg::PERM_TAB[row_reg][{g_reg + 3'd1, 1'b0}];
                else if (row_reg == 4'd9)
                    rd_addr = b2b_pkg::PERM_TAB[0][0];
                else
                    rd_addr = b2b_pkg::PERM_TAB[row_reg + 4'd1][0];
            end
            default: rd_addr = b2b_pkg::PERM_TAB[row_reg][0];
        endcase
    end

    assign mword = rd_zero_reg ? 64'd0 : rd_data_reg;

    always_comb
    begin
        q_in.a = v_reg[b2b_pkg::GA_TAB[g_reg]];
        q_in.b = v_reg[b2b_pkg::GB_TAB[g_reg]];
        q_in.c = v_reg[b2b_pkg::GC_TAB[g_reg]];
        q_in.d = v_reg[b2b_pkg::GD_TAB[g_reg]];
        if (state_reg == b2b_pkg::ST_GA)
            q_out = b2b_pkg::mix_first(q_in, mword);
        else
            q_out = b2b_pkg::mix_second(q_in, mword);
    end

    assign nb_eff   = (!msg.last_word || msg.bytes_valid > 4'd8) ? 4'd8 : msg.bytes_valid;
    assign word_eff = msg.msg_word & b2b_pkg::byte_mask(nb_eff);
    assign fill_base = open_reg ? fill_reg : 8'd0;
    assign fill_sum  = fill_base + {4'd0, nb_eff};

    assign words     = 4'((dl_clamp + 7'd7) >> 3);
    assign rem_bytes = dl_clamp - {1'b0, oidx_reg, 3'd0};
    assign out_cnt   = (rem_bytes > 7'd8) ? 4'd8 : rem_bytes[3:0];

    assign msg.ready        = (state_reg == b2b_pkg::ST_IDLE);
    assign dig.valid        = (state_reg == b2b_pkg::ST_OUT);
    assign dig.digest_word  = chain_reg[oidx_reg] & b2b_pkg::byte_mask(out_cnt);
    assign dig.digest_bytes = out_cnt;
    assign dig.digest_last  = ({1'b0, oidx_reg} + 4'd1 == words);

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        v_next         = v_reg;
        cnt_lo_next    = cnt_lo_reg;
        cnt_hi_next    = cnt_hi_reg;
        fill_next      = fill_reg;
        open_next      = open_reg;
        final_next     = final_reg;
        lim_next       = lim_reg;
        round_next     = round_reg;
        row_next       = row_reg;
        g_next         = g_reg;
        oidx_next      = oidx_reg;
        pend_word_next = pend_word_reg;
        pend_nb_next   = pend_nb_reg;
        pend_last_next = pend_last_reg;
        wr_en          = 1'b0;
        wr_addr        = fill_base[6:3];
        wr_data        = word_eff;
        lo_add         = 64'd0;

        case (state_reg)
            b2b_pkg::ST_IDLE:
            begin
                if (msg.valid)
                begin
                    if (!open_reg)
                    begin
                        for (int i = 0; i < 8; i++)
                            chain_next[i] = b2b_pkg::IV_TAB[i];
                        chain_next[0] = b2b_pkg::IV_TAB[0] ^ b2b_pkg::PARAM_CONST
                                        ^ {49'd0, kl_clamp, 8'd0} ^ {57'd0, dl_clamp};
                        cnt_hi_next = 64'd0;
                        open_next = 1'b1;
                    end
                    cnt_lo_next = open_reg ? cnt_lo_reg : 64'd0;
                    fill_next = fill_base;
                    round_next = '0;
                    row_next = 4'd0;
                    g_next = 3'd0;
                    if (nb_eff != 4'd0 && fill_base[7])
                    begin
                        lo_add = 64'd128;
                        pend_word_next = word_eff;
                        pend_nb_next = nb_eff;
                        pend_last_next = msg.last_word;
                        final_next = 1'b0;
                        lim_next = 5'd16;
                        state_next = b2b_pkg::ST_INIT;
                    end
                    else
                    begin
                        if (nb_eff != 4'd0)
                        begin
                            wr_en = 1'b1;
                            fill_next = fill_sum;
                        end
                        if (msg.last_word)
                        begin
                            lo_add = {56'd0, fill_next};
                            final_next = 1'b1;
                            lim_next = 5'((fill_next + 8'd7) >> 3);
                            state_next = b2b_pkg::ST_INIT;
                        end
                    end
                end
            end
            b2b_pkg::ST_POST:
            begin
                wr_en = 1'b1;
                wr_addr = 4'd0;
                wr_data = pend_word_reg;
                fill_next = {4'd0, pend_nb_reg};
                round_next = '0;
                row_next = 4'd0;
                g_next = 3'd0;
                if (pend_last_reg)
                begin
                    lo_add = {60'd0, pend_nb_reg};
                    final_next = 1'b1;
                    lim_next = 5'(({4'd0, pend_nb_reg} + 8'd7) >> 3);
                    state_next = b2b_pkg::ST_INIT;
                end
                else
                begin
                    state_next = b2b_pkg::ST_IDLE;
                end
            end
            b2b_pkg::ST_INIT:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_next[i] = chain_reg[i];
                    v_next[i+8] = b2b_pkg::IV_TAB[i];
                end
                v_next[12] = b2b_pkg::IV_TAB[4] ^ cnt_lo_reg;
                v_next[13] = b2b_pkg::IV_TAB[5] ^ cnt_hi_reg;
                v_next[14] = b2b_pkg::IV_TAB[6] ^ {64{final_reg}};
                state_next = b2b_pkg::ST_GA;
            end
            b2b_pkg::ST_GA, b2b_pkg::ST_GB:
            begin
                v_next[b2b_pkg::GA_TAB[g_reg]] = q_out.a;
                v_next[b2b_pkg::GB_TAB[g_reg]] = q_out.b;
                v_next[b2b_pkg::GC_TAB[g_reg]] = q_out.c;
                v_next[b2b_pkg::GD_TAB[g_reg]] = q_out.d;
                if (state_reg == b2b_pkg::ST_GA)
                begin
                    state_next = b2b_pkg::ST_GB;
                end
                else
                begin
                    g_next = g_reg + 3'd1;
                    state_next = b2b_pkg::ST_GA;
                    if (g_reg == 3'd7)
                    begin
                        round_next = round_reg + RW'(1);
                        row_next = (row_reg == 4'd9) ? 4'd0 : row_reg + 4'd1;
                        if (round_reg == RW'(ROUND_COUNT - 1))
                            state_next = b2b_pkg::ST_FOLD;
                    end
                end
            end
            b2b_pkg::ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] ^ v_reg[i] ^ v_reg[i+8];
                oidx_next = 3'd0;
                state_next = final_reg ? b2b_pkg::ST_OUT : b2b_pkg::ST_POST;
            end
            b2b_pkg::ST_OUT:
            begin
                if (dig.ready)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (dig.digest_last)
                    begin
                        open_next = 1'b0;
                        fill_next = 8'd0;
                        state_next = b2b_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = b2b_pkg::ST_IDLE;
        endcase

        lo_sum = cnt_lo_next + lo_add;
        if (lo_sum < lo_add)
            cnt_hi_next = cnt_hi_next + 64'd1;
        cnt_lo_next = lo_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2b_pkg::ST_IDLE;
            open_reg  <= 1'b0;
            fill_reg  <= 8'd0;
            final_reg <= 1'b0;
            round_reg <= '0;
            row_reg   <= 4'd0;
            g_reg     <= 3'd0;
            oidx_reg  <= 3'd0;
            lim_reg   <= 5'd16;
            cnt_lo_reg <= 64'd0;
            cnt_hi_reg <= 64'd0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            fill_reg  <= fill_next;
            final_reg <= final_next;
            round_reg <= round_next;
            row_reg   <= row_next;
            g_reg     <= g_next;
            oidx_reg  <= oidx_next;
            lim_reg   <= lim_next;
            cnt_lo_reg <= cnt_lo_next;
            cnt_hi_reg <= cnt_hi_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg     <= chain_next;
        v_reg         <= v_next;
        pend_word_reg <= pend_word_next;
        pend_nb_reg   <= pend_nb_next;
    end

endmodule
